[design/gmp_pkg.sv]
// ----------------------------------------------------------------------------
// gmp_pkg: shared types and codes of the grid maze first-step planner
// Cell, command and status types, result codes, move directions.
// ----------------------------------------------------------------------------
package gmp_pkg;

    localparam int DEF_ROWS  = 5;
    localparam int DEF_COLS  = 9;

    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int LEN_W     = 6;
    localparam int ST_W      = 2;
    localparam int DIR_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_VWALL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HWALL = 2'd1;

    localparam logic [ST_W-1:0] ST_STEP    = 2'd0;
    localparam logic [ST_W-1:0] ST_UNREACH = 2'd1;
    localparam logic [ST_W-1:0] ST_SAME    = 2'd2;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cell;

    typedef struct packed {
        logic             load;
        logic             init;
        logic             pop;
        logic             take;
        logic             expand;
        logic             rd_start;
        logic             take_d;
        logic             rd_nb;
        logic             emit;
        logic [ST_W-1:0]  code;
        logic             src_start;
        logic [DIR_W-1:0] dir;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic same_cell;
        logic empty;
        logic q_is_start;
        logic start_reached;
        logic nb_ok;
        logic dist_match;
    } t_stat;

    // tie order on the first step: up, left, right, down
    function automatic logic [DIR_W-1:0] pick_dir(input logic [1:0] k);
        logic [DIR_W-1:0] d;
        case (k)
            2'd0:    d = DIR_UP;
            2'd1:    d = DIR_LEFT;
            2'd2:    d = DIR_RIGHT;
            default: d = DIR_DOWN;
        endcase
        return d;
    endfunction

endpackage

[design/gmp_ctrl.sv]
// ----------------------------------------------------------------------------
// gmp_ctrl: search sequencer
// Runs the breadth-first sweep from the goal, then picks the first step.
// ----------------------------------------------------------------------------
module gmp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gmp_pkg::t_stat i_stat,
    output gmp_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import gmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_POP,
        S_TAKE,
        S_EXPAND,
        S_FINAL,
        S_DWAIT,
        S_NREAD,
        S_NCHK
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.code = ST_STEP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.in_range) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = ST_UNREACH;
                    end else if (i_stat.same_cell) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.code = ST_SAME;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_POP;
            end
            S_POP: begin
                if (i_stat.empty) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_k        = 2'd0;
                n_state    = i_stat.q_is_start ? S_FINAL : S_EXPAND;
            end
            S_EXPAND: begin
                o_cmd.expand = 1'b1;
                o_cmd.dir    = r_k;
                n_k          = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_POP;
                end
            end
            S_FINAL: begin
                if (!i_stat.start_reached) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_UNREACH;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_DWAIT;
                end
            end
            S_DWAIT: begin
                o_cmd.take_d = 1'b1;
                n_k          = 2'd0;
                n_state      = S_NREAD;
            end
            S_NREAD: begin
                o_cmd.src_start = 1'b1;
                o_cmd.dir       = pick_dir(r_k);
                o_cmd.rd_nb     = 1'b1;
                n_state         = S_NCHK;
            end
            S_NCHK: begin
                o_cmd.src_start = 1'b1;
                o_cmd.dir       = pick_dir(r_k);
                if (i_stat.nb_ok && i_stat.dist_match) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_STEP;
                    n_state    = S_IDLE;
                end else if (r_k == 2'd3) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_UNREACH;
                    n_state    = S_IDLE;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_NREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[design/gmp_dpath.sv]
// ----------------------------------------------------------------------------
// gmp_dpath: search datapath
// Wall registers, neighbor unit, reached bits, frontier queue, distance store.
// ----------------------------------------------------------------------------
module gmp_dpath #(
    parameter int GRID_ROWS = gmp_pkg::DEF_ROWS,
    parameter int GRID_COLS = gmp_pkg::DEF_COLS,
    parameter int CFG_W     = ((GRID_ROWS * (GRID_COLS + 1)) > ((GRID_ROWS + 1) * GRID_COLS))
                              ? (GRID_ROWS * (GRID_COLS + 1)) : ((GRID_ROWS + 1) * GRID_COLS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gmp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic [gmp_pkg::ROW_W-1:0]     i_start_row,
    input  logic [gmp_pkg::COL_W-1:0]     i_start_col,
    input  logic [gmp_pkg::ROW_W-1:0]     i_goal_row,
    input  logic [gmp_pkg::COL_W-1:0]     i_goal_col,
    input  gmp_pkg::t_cmd                 i_cmd,
    output gmp_pkg::t_stat                o_stat,
    output logic                          o_valid,
    output logic [gmp_pkg::ST_W-1:0]      o_status,
    output logic [gmp_pkg::ROW_W-1:0]     o_next_row,
    output logic [gmp_pkg::COL_W-1:0]     o_next_col,
    output logic [gmp_pkg::DIR_W-1:0]     o_direction,
    output logic [gmp_pkg::LEN_W-1:0]     o_path_length
);
    import gmp_pkg::*;

    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int VW     = GRID_ROWS * (GRID_COLS + 1);
    localparam int HW     = (GRID_ROWS + 1) * GRID_COLS;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int V_IX_W = $clog2(VW);
    localparam int H_IX_W = $clog2(HW);

    logic [VW-1:0]    r_vwall;
    logic [HW-1:0]    r_hwall;
    t_cell            r_start, r_goal, r_cur;
    logic [CNT_W-1:0] r_head, r_tail;
    logic [CELLS-1:0] r_reached;

    t_cell            fifo_mem [CELLS];
    t_cell            r_fifo_q;
    logic [LEN_W-1:0] dist_mem [CELLS];
    logic [LEN_W-1:0] r_dist_q;
    logic [LEN_W-1:0] r_d;

    logic             r_valid;
    logic [ST_W-1:0]  r_status;
    t_cell            r_next;
    logic [DIR_W-1:0] r_dir;
    logic [LEN_W-1:0] r_len;

    t_cell             src, nb;
    logic              nb_open, nb_new;
    logic [V_IX_W-1:0] vbase;
    logic [H_IX_W-1:0] hbase;
    logic [VW-1:0]     vsh_r, vsh_l;
    logic [HW-1:0]     hsh_d, hsh_u;
    logic [IDX_W-1:0]  nb_idx, start_idx, goal_idx, q_idx;
    logic [IDX_W-1:0]  dist_ra, dist_wa;
    logic              dist_re, dist_we;
    logic [LEN_W-1:0]  dist_wd;

    function automatic logic [IDX_W-1:0] cell_idx(input t_cell c);
        return IDX_W'(c.row) * IDX_W'(GRID_COLS) + IDX_W'(c.col);
    endfunction

    // neighbor of the source cell in the commanded direction
    always_comb begin
        src   = i_cmd.src_start ? r_start : r_cur;
        vbase = V_IX_W'(src.row) * V_IX_W'(GRID_COLS + 1) + V_IX_W'(src.col);
        hbase = H_IX_W'(src.row) * H_IX_W'(GRID_COLS) + H_IX_W'(src.col);
        vsh_l = r_vwall >> vbase;
        vsh_r = r_vwall >> (vbase + V_IX_W'(1));
        hsh_u = r_hwall >> hbase;
        hsh_d = r_hwall >> (hbase + H_IX_W'(GRID_COLS));
        nb      = src;
        nb_open = 1'b0;
        case (i_cmd.dir)
            DIR_RIGHT: begin
                nb_open = (src.col != COL_W'(GRID_COLS - 1)) && !vsh_r[0];
                nb.col  = src.col + COL_W'(1);
            end
            DIR_DOWN: begin
                nb_open = (src.row != ROW_W'(GRID_ROWS - 1)) && !hsh_d[0];
                nb.row  = src.row + ROW_W'(1);
            end
            DIR_LEFT: begin
                nb_open = (src.col != '0) && !vsh_l[0];
                nb.col  = src.col - COL_W'(1);
            end
            DIR_UP: begin
                nb_open = (src.row != '0) && !hsh_u[0];
                nb.row  = src.row - ROW_W'(1);
            end
            default: begin
                nb_open = 1'b0;
            end
        endcase
    end

    assign nb_idx    = cell_idx(nb);
    assign start_idx = cell_idx(r_start);
    assign goal_idx  = cell_idx(r_goal);
    assign q_idx     = cell_idx(r_fifo_q);
    assign nb_new    = nb_open && !r_reached[nb_idx];

    always_comb begin
        o_stat.in_range      = (i_start_row < ROW_W'(GRID_ROWS)) &&
                               (i_start_col < COL_W'(GRID_COLS)) &&
                               (i_goal_row < ROW_W'(GRID_ROWS)) &&
                               (i_goal_col < COL_W'(GRID_COLS));
        o_stat.same_cell     = (i_start_row == i_goal_row) && (i_start_col == i_goal_col);
        o_stat.empty         = (r_head == r_tail);
        o_stat.q_is_start    = (r_fifo_q == r_start);
        o_stat.start_reached = r_reached[start_idx];
        o_stat.nb_ok         = nb_open && r_reached[nb_idx];
        o_stat.dist_match    = ((r_dist_q + LEN_W'(1)) == r_d);
    end

    always_comb begin
        dist_re = i_cmd.take || i_cmd.rd_start || i_cmd.rd_nb;
        if (i_cmd.take) begin
            dist_ra = q_idx;
        end else if (i_cmd.rd_start) begin
            dist_ra = start_idx;
        end else begin
            dist_ra = nb_idx;
        end
        dist_we = i_cmd.init || (i_cmd.expand && nb_new);
        dist_wa = i_cmd.init ? goal_idx : nb_idx;
        dist_wd = i_cmd.init ? '0 : (r_dist_q + LEN_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_wa] <= dist_wd;
        end
        if (dist_re) begin
            r_dist_q <= dist_mem[dist_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            fifo_mem[IDX_W'(0)] <= r_goal;
        end else if (i_cmd.expand && nb_new) begin
            fifo_mem[r_tail[IDX_W-1:0]] <= nb;
        end
        if (i_cmd.pop) begin
            r_fifo_q <= fifo_mem[r_head[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= '{row: i_start_row, col: i_start_col};
            r_goal  <= '{row: i_goal_row, col: i_goal_col};
        end
        if (i_cmd.take) begin
            r_cur <= r_fifo_q;
        end
        if (i_cmd.take_d) begin
            r_d <= r_dist_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vwall   <= '0;
            r_hwall   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_reached <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_VWALL) begin
                r_vwall <= i_cfg_data[VW-1:0];
            end
            if (i_cfg_we && i_cfg_idx == REG_HWALL) begin
                r_hwall <= i_cfg_data[HW-1:0];
            end
            if (i_cmd.init) begin
                r_reached <= CELLS'(1) << goal_idx;
                r_head    <= '0;
                r_tail    <= CNT_W'(1);
            end else begin
                if (i_cmd.pop) begin
                    r_head <= r_head + CNT_W'(1);
                end
                if (i_cmd.expand && nb_new) begin
                    r_reached[nb_idx] <= 1'b1;
                    r_tail            <= r_tail + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.code;
            if (i_cmd.code == ST_STEP) begin
                r_next <= nb;
                r_dir  <= i_cmd.dir;
                r_len  <= r_d;
            end else begin
                r_next <= '0;
                r_dir  <= '0;
                r_len  <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_next_row    = r_next.row;
    assign o_next_col    = r_next.col;
    assign o_direction   = r_dir;
    assign o_path_length = r_len;

`ifndef SYNTHESIS
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("frontier head passed tail");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CNT_W'(CELLS))
        else $error("frontier overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_head != r_tail))
        else $error("pop from empty frontier");

    a_step_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.code == ST_STEP) |=> (o_valid && o_path_length != '0))
        else $error("step reported with zero path length");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_STEP) |->
        (o_next_row == '0 && o_next_col == '0 && o_direction == '0 && o_path_length == '0))
        else $error("nonzero fields on a failed query");
`endif

endmodule

[design/grid_maze_path_first_step.sv]
// ----------------------------------------------------------------------------
// grid_maze_path_first_step: first step of a shortest path through a grid maze
// A cell out of range or start equal to goal is answered without a search;
// else the search state is cleared, cells are expanded (queue read, distance
// read, four neighbor checks) until the start cell is taken or the queue is
// empty, the start distance is read and the step picked. One query at a time;
// busy is high in a search until the word is issued; the receiver cannot stall.
// Synchronous active-low reset clears the walls and all control state.
// ----------------------------------------------------------------------------
module grid_maze_path_first_step #(
    parameter int GRID_ROWS = gmp_pkg::DEF_ROWS,
    parameter int GRID_COLS = gmp_pkg::DEF_COLS,
    parameter int CFG_W     = ((GRID_ROWS * (GRID_COLS + 1)) > ((GRID_ROWS + 1) * GRID_COLS))
                              ? (GRID_ROWS * (GRID_COLS + 1)) : ((GRID_ROWS + 1) * GRID_COLS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gmp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [gmp_pkg::ROW_W-1:0]     i_start_row,
    input  logic [gmp_pkg::COL_W-1:0]     i_start_col,
    input  logic [gmp_pkg::ROW_W-1:0]     i_goal_row,
    input  logic [gmp_pkg::COL_W-1:0]     i_goal_col,
    output logic                          o_valid,
    output logic [gmp_pkg::ST_W-1:0]      o_status,
    output logic [gmp_pkg::ROW_W-1:0]     o_next_row,
    output logic [gmp_pkg::COL_W-1:0]     o_next_col,
    output logic [gmp_pkg::DIR_W-1:0]     o_direction,
    output logic [gmp_pkg::LEN_W-1:0]     o_path_length
);
    import gmp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gmp_dpath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .CFG_W     (CFG_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start_row   (i_start_row),
        .i_start_col   (i_start_col),
        .i_goal_row    (i_goal_row),
        .i_goal_col    (i_goal_col),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_next_row    (o_next_row),
        .o_next_col    (o_next_col),
        .o_direction   (o_direction),
        .o_path_length (o_path_length)
    );

endmodule
